>>> hw/rtl/flptw_pkg.sv
// Shared types, constants and the microcode ROM of the page table walker.
package flptw_pkg;

  localparam int unsigned TABLE_ENTRIES = 512;
  localparam int unsigned IDX_W         = 9;
  localparam int unsigned PAGE_W        = 12;
  localparam int unsigned VA_W          = 48;
  localparam int unsigned PA_W          = 52;
  localparam int unsigned PTR_W         = PA_W - PAGE_W;
  localparam int unsigned ENTRY_W       = 64;
  localparam int unsigned FLAGS_W       = 12;
  localparam int unsigned ROOT_W        = 6;
  localparam int unsigned FREE_W        = 7;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 7;

  localparam logic [ENTRY_W-1:0] LINK_FLAGS = 64'h3;
  localparam logic [1:0]         LVL_LEAF   = 2'd3;
  localparam logic               REQ_MAP    = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROOT_FRAME = 1'd0,
    REG_FIRST_FREE = 1'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNMAPPED = 2'd1,
    ST_NOFRAME  = 2'd2,
    ST_OUTSIDE  = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_RCLR   = 5'd0,
    S_IDLE   = 5'd1,
    S_CHK    = 5'd2,
    S_EVAL   = 5'd3,
    S_FOLLOW = 5'd4,
    S_NEXT   = 5'd5,
    S_LEAF   = 5'd6,
    S_LEAFWR = 5'd7,
    S_MISS   = 5'd8,
    S_ALLOC  = 5'd9,
    S_GRAB   = 5'd10,
    S_CLR    = 5'd11,
    S_LINK   = 5'd12,
    S_OUT    = 5'd13,
    S_UNMAP  = 5'd14,
    S_NOFRM  = 5'd15,
    S_TOK    = 5'd16,
    S_MOK    = 5'd17,
    S_DONE   = 5'd18,
    S_HOLD   = 5'd19
  } step_e;

  typedef enum logic [3:0] {
    C_NEVER    = 4'd0,
    C_ALWAYS   = 4'd1,
    C_CLR_MORE = 4'd2,
    C_NO_REQ   = 4'd3,
    C_OOB      = 4'd4,
    C_ABSENT   = 4'd5,
    C_LVL_LAST = 4'd6,
    C_NOT_LEAF = 4'd7,
    C_XLATE    = 4'd8,
    C_NO_FRAME = 4'd9,
    C_OUT_FREE = 4'd10
  } cond_e;

  typedef enum logic {
    A_WALK  = 1'b0,
    A_CLEAR = 1'b1
  } asel_e;

  typedef enum logic [1:0] {
    W_ZERO = 2'd0,
    W_LINK = 2'd1,
    W_LEAF = 2'd2
  } wsel_e;

  typedef struct packed {
    logic                req_type;
    logic [VA_W-1:0]     virt_addr;
    logic [PA_W-1:0]     map_addr;
    logic [FLAGS_W-1:0]  leaf_flags;
  } flptw_req_t;

  typedef struct packed {
    logic [PA_W-1:0] phys_result;
    logic [1:0]      status;
  } flptw_rsp_t;

  // One control word of the microprogram.
  typedef struct packed {
    cond_e   cond;
    step_e   target;
    logic    mem_rd;
    logic    mem_wr;
    asel_e   asel;
    wsel_e   wsel;
    logic    clr_inc;
    logic    ld_req;
    logic    ld_frame;
    logic    lvl_inc;
    logic    alloc;
    logic    ld_link;
    logic    set_st;
    logic    res_zero;
    status_e st;
    logic    emit;
  } ucode_t;

  // Datapath conditions sampled by the sequencer.
  typedef struct packed {
    logic req_valid;
    logic clr_last;
    logic oob;
    logic absent;
    logic lvl_last;
    logic map_leaf;
    logic is_map;
    logic no_frame;
    logic out_free;
  } flags_t;

  function automatic ucode_t ucode_rom(step_e s);
    ucode_t u;
    u = '0;
    unique case (s)
      S_RCLR: begin
        u.mem_wr = 1'b1; u.asel = A_CLEAR; u.wsel = W_ZERO; u.clr_inc = 1'b1;
        u.cond = C_CLR_MORE; u.target = S_RCLR;
      end
      S_IDLE: begin
        u.ld_req = 1'b1; u.cond = C_NO_REQ; u.target = S_IDLE;
      end
      S_CHK: begin
        u.mem_rd = 1'b1; u.asel = A_WALK; u.cond = C_OOB; u.target = S_OUT;
      end
      S_EVAL: begin
        u.cond = C_ABSENT; u.target = S_MISS;
      end
      S_FOLLOW: begin
        u.ld_frame = 1'b1; u.lvl_inc = 1'b1; u.cond = C_LVL_LAST; u.target = S_TOK;
      end
      S_NEXT: begin
        u.cond = C_NOT_LEAF; u.target = S_CHK;
      end
      S_LEAF: begin
        u.cond = C_OOB; u.target = S_OUT;
      end
      S_LEAFWR: begin
        u.mem_wr = 1'b1; u.asel = A_WALK; u.wsel = W_LEAF;
        u.cond = C_ALWAYS; u.target = S_MOK;
      end
      S_MISS: begin
        u.cond = C_XLATE; u.target = S_UNMAP;
      end
      S_ALLOC: begin
        u.cond = C_NO_FRAME; u.target = S_NOFRM;
      end
      S_GRAB: begin
        u.alloc = 1'b1;
      end
      S_CLR: begin
        u.mem_wr = 1'b1; u.asel = A_CLEAR; u.wsel = W_ZERO; u.clr_inc = 1'b1;
        u.cond = C_CLR_MORE; u.target = S_CLR;
      end
      S_LINK: begin
        u.mem_wr = 1'b1; u.asel = A_WALK; u.wsel = W_LINK;
        u.ld_link = 1'b1; u.lvl_inc = 1'b1;
        u.cond = C_ALWAYS; u.target = S_NEXT;
      end
      S_OUT: begin
        u.set_st = 1'b1; u.res_zero = 1'b1; u.st = ST_OUTSIDE;
        u.cond = C_ALWAYS; u.target = S_DONE;
      end
      S_UNMAP: begin
        u.set_st = 1'b1; u.res_zero = 1'b1; u.st = ST_UNMAPPED;
        u.cond = C_ALWAYS; u.target = S_DONE;
      end
      S_NOFRM: begin
        u.set_st = 1'b1; u.res_zero = 1'b1; u.st = ST_NOFRAME;
        u.cond = C_ALWAYS; u.target = S_DONE;
      end
      S_TOK: begin
        u.set_st = 1'b1; u.st = ST_OK;
        u.cond = C_ALWAYS; u.target = S_DONE;
      end
      S_MOK: begin
        // falls through into S_DONE
        u.set_st = 1'b1; u.res_zero = 1'b1; u.st = ST_OK;
      end
      S_DONE: begin
        u.emit = 1'b1; u.cond = C_OUT_FREE; u.target = S_IDLE;
      end
      S_HOLD: begin
        u.cond = C_ALWAYS; u.target = S_DONE;
      end
      default: begin
        u.cond = C_ALWAYS; u.target = S_IDLE;
      end
    endcase
    return u;
  endfunction

endpackage

>>> hw/rtl/flptw_ram.sv
// Generic single-port RAM with registered read data.
module flptw_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/flptw_useq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
module flptw_useq import flptw_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  flags_t flags_i,
  output ucode_t uc_o
);

  step_e  upc_q, upc_d;
  ucode_t uc;
  logic   taken;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= S_RCLR;
    end else begin
      upc_q <= upc_d;
    end
  end

  always_comb begin
    uc = ucode_rom(upc_q);
    unique case (uc.cond)
      C_NEVER:    taken = 1'b0;
      C_ALWAYS:   taken = 1'b1;
      C_CLR_MORE: taken = !flags_i.clr_last;
      C_NO_REQ:   taken = !flags_i.req_valid;
      C_OOB:      taken = flags_i.oob;
      C_ABSENT:   taken = flags_i.absent;
      C_LVL_LAST: taken = flags_i.lvl_last;
      C_NOT_LEAF: taken = !flags_i.map_leaf;
      C_XLATE:    taken = !flags_i.is_map;
      C_NO_FRAME: taken = flags_i.no_frame;
      C_OUT_FREE: taken = flags_i.out_free;
      default:    taken = 1'b0;
    endcase
    upc_d = taken ? uc.target : step_e'(upc_q + 5'd1);
  end

  assign uc_o = uc;

endmodule

>>> hw/rtl/flptw_dpath.sv
// Walker datapath: request and walk registers, allocator, table RAM, output register.
module flptw_dpath import flptw_pkg::*; #(
  parameter int unsigned NUM_FRAMES = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ucode_t                uc_i,
  input  logic                  in_valid_i,
  input  flptw_req_t            in_req_i,
  input  logic                  out_stall_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output flags_t                flags_o,
  output logic                  out_valid_o,
  output flptw_rsp_t            out_rsp_o
);

  localparam int unsigned FRAME_W = $clog2(NUM_FRAMES);
  localparam int unsigned NFF_W   = ($clog2(NUM_FRAMES + 1) > FREE_W) ?
                                    $clog2(NUM_FRAMES + 1) : FREE_W;
  localparam int unsigned DEPTH   = NUM_FRAMES * TABLE_ENTRIES;
  localparam int unsigned ADDR_W  = FRAME_W + IDX_W;

  flptw_req_t          req_q;
  logic [FRAME_W-1:0]  frame_q;
  logic                oob_q;
  logic [1:0]          lvl_q;
  logic [IDX_W-1:0]    clr_q;
  logic [FRAME_W-1:0]  alloc_q;
  logic [NFF_W-1:0]    nff_q;
  logic [ROOT_W-1:0]   root_q;
  logic [PA_W-1:0]     xres_q;
  status_e             st_q;
  flptw_rsp_t          rsp_q;
  logic                out_valid_q, out_valid_d;

  logic [IDX_W-1:0]    walk_idx;
  logic [ADDR_W-1:0]   mem_addr;
  logic [ENTRY_W-1:0]  wdata;
  logic [ENTRY_W-1:0]  rdata;
  logic                req_fire;
  logic                out_free;
  logic                emit_fire;

  assign req_fire  = uc_i.ld_req && in_valid_i;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign emit_fire = uc_i.emit && out_free;

  always_comb begin
    unique case (lvl_q)
      2'd0:    walk_idx = req_q.virt_addr[47:39];
      2'd1:    walk_idx = req_q.virt_addr[38:30];
      2'd2:    walk_idx = req_q.virt_addr[29:21];
      default: walk_idx = req_q.virt_addr[20:12];
    endcase
  end

  assign mem_addr = (uc_i.asel == A_CLEAR) ? {alloc_q, clr_q} : {frame_q, walk_idx};

  always_comb begin
    unique case (uc_i.wsel)
      W_ZERO:  wdata = '0;
      W_LINK:  wdata = {{(ENTRY_W - PA_W){1'b0}}, PTR_W'(alloc_q), {PAGE_W{1'b0}}}
                       | LINK_FLAGS;
      W_LEAF:  wdata = ENTRY_W'(req_q.map_addr) | ENTRY_W'(req_q.leaf_flags);
      default: wdata = '0;
    endcase
  end

  flptw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (uc_i.mem_wr),
    .re_i    (uc_i.mem_rd),
    .addr_i  (mem_addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  // Control state: walk level, clear counter, allocator, registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q   <= '0;
      clr_q   <= '0;
      alloc_q <= '0;  // reset clear pass sweeps frame 0, the reset root
      nff_q   <= NFF_W'(1);
      root_q  <= '0;
    end else begin
      if (req_fire) begin
        lvl_q <= '0;
      end else if (uc_i.lvl_inc) begin
        lvl_q <= lvl_q + 2'd1;
      end
      if (uc_i.alloc) begin
        clr_q <= '0;
      end else if (uc_i.clr_inc) begin
        clr_q <= clr_q + IDX_W'(1);
      end
      if (uc_i.alloc) begin
        alloc_q <= nff_q[FRAME_W-1:0];
        nff_q   <= nff_q + NFF_W'(1);
      end
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_ROOT_FRAME: root_q <= cfg_data_i[ROOT_W-1:0];
          REG_FIRST_FREE: nff_q  <= NFF_W'(cfg_data_i[FREE_W-1:0]);
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      req_q   <= in_req_i;
      frame_q <= FRAME_W'(root_q);
      oob_q   <= PTR_W'(root_q) >= PTR_W'(NUM_FRAMES);
    end else if (uc_i.ld_frame) begin
      frame_q <= rdata[PAGE_W +: FRAME_W];
      oob_q   <= rdata[PA_W-1:PAGE_W] >= PTR_W'(NUM_FRAMES);
    end else if (uc_i.ld_link) begin
      frame_q <= alloc_q;
      oob_q   <= 1'b0;
    end
    if (uc_i.ld_frame) begin
      xres_q <= {rdata[PA_W-1:PAGE_W], req_q.virt_addr[PAGE_W-1:0]};
    end else if (uc_i.set_st && uc_i.res_zero) begin
      xres_q <= '0;
    end
    if (uc_i.set_st) begin
      st_q <= uc_i.st;
    end
    if (emit_fire) begin
      rsp_q.phys_result <= xres_q;
      rsp_q.status      <= st_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign flags_o.req_valid = in_valid_i;
  assign flags_o.clr_last  = (clr_q == '1);
  assign flags_o.oob       = oob_q;
  assign flags_o.absent    = !rdata[0];
  assign flags_o.lvl_last  = (lvl_q == LVL_LEAF);
  assign flags_o.map_leaf  = (req_q.req_type == REQ_MAP) && (lvl_q == LVL_LEAF);
  assign flags_o.is_map    = (req_q.req_type == REQ_MAP);
  assign flags_o.no_frame  = (nff_q >= NFF_W'(NUM_FRAMES));
  assign flags_o.out_free  = out_free;

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

>>> hw/rtl/four_level_page_table_walker_top.sv
// Top level of the four-level page table walker.
// The walker keeps NUM_FRAMES page-table frames of 512 64-bit entries in one
// single-port RAM and takes one request at a time. A translate request walks
// four levels. Each table a map request has to allocate is cleared first, one
// entry per cycle over all 512 entries of the new frame. The microcode loop
// sets the pace: every level costs a RAM read, a check and a pointer update on
// the one RAM port. After reset the block clears all 512 entries of frame 0
// (the reset root table) and holds in_stall_o high meanwhile; configuration
// writes are taken during that pass. A finished result sits in an output
// register, and a new request can be accepted while it waits to be taken.
module four_level_page_table_walker_top import flptw_pkg::*; #(
  parameter int unsigned NUM_FRAMES = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  flptw_req_t            in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output flptw_rsp_t            out_rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  ucode_t uc;
  flags_t flags;

  flptw_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .uc_o    (uc)
  );

  flptw_dpath #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .uc_i        (uc),
    .in_valid_i  (in_valid_i),
    .in_req_i    (in_req_i),
    .out_stall_i (out_stall_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .flags_o     (flags),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

  assign in_stall_o = !uc.ld_req;

  // one request in flight at a time
  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while another is in progress");

  a_alloc_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    uc.alloc |-> !flags.no_frame)
    else $error("frame allocated beyond the store");

  a_no_outside_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    uc.mem_wr && uc.asel == A_WALK |-> !flags.oob)
    else $error("table write through a pointer outside the store");

  a_error_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status != ST_OK |-> out_rsp_o.phys_result == '0)
    else $error("nonzero address returned with an error status");

endmodule
